### hdl/scrs_pkg.sv
package scrs_pkg;

  // Result kinds as they appear on the result channel.
  localparam logic [1:0] KIND_ROBOT  = 2'd0;
  localparam logic [1:0] KIND_OURS   = 2'd1;
  localparam logic [1:0] KIND_OPPS   = 2'd2;
  localparam logic [1:0] KIND_BORDER = 2'd3;

  // Register indexes; register i sits at byte address 4*i.
  localparam logic [2:0] REG_VERTICAL_MODE = 3'd0;
  localparam logic [2:0] REG_FIELD_TOP     = 3'd1;
  localparam logic [2:0] REG_SCAN_STEP     = 3'd2;
  localparam logic [2:0] REG_SCAN_LIMIT    = 3'd3;
  localparam logic [2:0] REG_LINE_LENGTH   = 3'd4;

  // Slots of the per-item result bundle, in delivery order.
  localparam int SLOT_ROBOT  = 0;
  localparam int SLOT_OURS   = 1;
  localparam int SLOT_OPPS   = 2;
  localparam int SLOT_BORDER = 3;
  localparam int NUM_SLOTS   = 4;

  // Run length loaded at each frame start.
  localparam int PREV_RESET = 1000;

  // Register reset values.
  localparam logic [6:0]  SCAN_STEP_RESET   = 7'd4;
  localparam logic [9:0]  SCAN_LIMIT_RESET  = 10'd636;
  localparam logic [10:0] LINE_LENGTH_RESET = 11'd640;

  typedef struct packed {
    logic               vertical_mode;
    logic signed [10:0] field_top;
    logic [6:0]         scan_step;
    logic [9:0]         scan_limit;
    logic [10:0]        line_length;
  } cfg_t;

endpackage

### hdl/scrs_cfg.sv
module scrs_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output scrs_pkg::cfg_t      cfg
);

  scrs_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        scrs_pkg::REG_VERTICAL_MODE: cfg_nxt.vertical_mode = pwdata[0];
        scrs_pkg::REG_FIELD_TOP:     cfg_nxt.field_top     = $signed(pwdata[10:0]);
        scrs_pkg::REG_SCAN_STEP:     cfg_nxt.scan_step     = pwdata[6:0];
        scrs_pkg::REG_SCAN_LIMIT:    cfg_nxt.scan_limit    = pwdata[9:0];
        scrs_pkg::REG_LINE_LENGTH:   cfg_nxt.line_length   = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scrs_pkg::REG_VERTICAL_MODE: prdata = {31'd0, cfg_r.vertical_mode};
      scrs_pkg::REG_FIELD_TOP:     prdata = {21'd0, cfg_r.field_top};
      scrs_pkg::REG_SCAN_STEP:     prdata = {25'd0, cfg_r.scan_step};
      scrs_pkg::REG_SCAN_LIMIT:    prdata = {22'd0, cfg_r.scan_limit};
      scrs_pkg::REG_LINE_LENGTH:   prdata = {21'd0, cfg_r.line_length};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertical_mode <= 1'b0;
      cfg_r.field_top     <= 11'sd0;
      cfg_r.scan_step     <= scrs_pkg::SCAN_STEP_RESET;
      cfg_r.scan_limit    <= scrs_pkg::SCAN_LIMIT_RESET;
      cfg_r.line_length   <= scrs_pkg::LINE_LENGTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/scrs_run_core.sv
module scrs_run_core #(
  parameter int COORD_BITS = 10,
  parameter int COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scrs_pkg::cfg_t        cfg,
  input  logic                  accept,
  input  logic [COORD_BITS-1:0] pos,
  input  logic [COORD_BITS-1:0] line,
  input  logic                  is_green,
  input  logic                  is_white,
  input  logic                  is_ours,
  input  logic                  is_opps,
  input  logic                  line_start,
  input  logic                  line_end,
  input  logic                  frame_start,
  output logic [scrs_pkg::NUM_SLOTS-1:0] res_mask,
  output logic [COORD_BITS-1:0] res_line,
  output logic signed [COORD_BITS:0] res_end,
  output logic [COORD_BITS-1:0] res_robot_start,
  output logic [COORD_BITS-1:0] res_ours_start,
  output logic [COORD_BITS-1:0] res_opps_start,
  output logic [COORD_BITS-1:0] res_field_min,
  output logic [COORD_BITS-1:0] res_field_max
);

  localparam int CB     = COORD_BITS;
  localparam int NB     = COUNT_BITS;
  localparam int FMIN_W = (CB > 11) ? CB : 11;
  localparam int PRL_W  = (CB + 1 > 11) ? CB + 1 : 11;
  localparam int CW     = PRL_W + 1;
  localparam int CMP_W  = (CB >= 11) ? CB + 1 : 12;
  localparam int LIM_W  = (CB > 10) ? CB : 10;
  localparam int MW     = NB + 7;
  localparam logic [NB-1:0] CNT_MAX = {NB{1'b1}};

  function automatic logic [NB-1:0] sat_inc(input logic [NB-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + NB'(1);
  endfunction

  logic                    fr_v_r, fr_v_nxt;
  logic [CB-1:0]           frs_r, frs_nxt;
  logic signed [CB:0]      fre_r, fre_nxt;
  logic [NB-1:0]           fgc_r, fgc_nxt, foc_r, foc_nxt;
  logic [FMIN_W-1:0]       fmin_r, fmin_nxt;
  logic [CB-1:0]           fmax_r, fmax_nxt;
  logic                    ff_r, ff_nxt;
  logic signed [PRL_W-1:0] prl_r, prl_nxt, prl_base;
  logic                    rb_v_r, rb_v_nxt;
  logic [CB-1:0]           rbs_r, rbs_nxt;
  logic [NB-1:0]           rgc_r, rgc_nxt, roc_r, roc_nxt, rwc_r, rwc_nxt;
  logic                    ou_v_r, ou_v_nxt, op_v_r, op_v_nxt;
  logic [CB-1:0]           ous_r, ous_nxt, ops_r, ops_nxt;

  logic                    in_field, at_limit, white_ok;
  logic signed [CMP_W-1:0] row_s, top_s;
  logic [CB-1:0]           row;
  logic signed [CB:0]      end_v;
  logic signed [CW-1:0]    run_diff, run_abs;
  logic [MW-1:0]           w_ext, o_ext;
  logic [scrs_pkg::NUM_SLOTS-1:0] mask;

  assign row      = cfg.vertical_mode ? pos : line;
  assign row_s    = $signed(CMP_W'(row));
  assign top_s    = CMP_W'(cfg.field_top);
  assign in_field = row_s > top_s;
  assign at_limit = LIM_W'(pos) >= LIM_W'(cfg.scan_limit);
  assign end_v    = $signed({1'b0, pos}) - $signed((CB + 1)'(cfg.scan_step));
  assign prl_base = frame_start ? PRL_W'(scrs_pkg::PREV_RESET) : prl_r;

  always_comb begin
    // Line start clears the line state before the sample is applied.
    fr_v_nxt = line_start ? 1'b0 : fr_v_r;
    frs_nxt  = line_start ? '0 : frs_r;
    fre_nxt  = line_start ? '1 : fre_r;
    fgc_nxt  = line_start ? '0 : fgc_r;
    foc_nxt  = line_start ? '0 : foc_r;
    fmin_nxt = line_start ? FMIN_W'(cfg.line_length) : fmin_r;
    fmax_nxt = line_start ? '0 : fmax_r;
    ff_nxt   = line_start ? 1'b0 : ff_r;
    rb_v_nxt = line_start ? 1'b0 : rb_v_r;
    rbs_nxt  = line_start ? '0 : rbs_r;
    rgc_nxt  = line_start ? '0 : rgc_r;
    roc_nxt  = line_start ? '0 : roc_r;
    rwc_nxt  = line_start ? '0 : rwc_r;
    ou_v_nxt = line_start ? 1'b0 : ou_v_r;
    ous_nxt  = line_start ? '0 : ous_r;
    op_v_nxt = line_start ? 1'b0 : op_v_r;
    ops_nxt  = line_start ? '0 : ops_r;
    prl_nxt  = prl_base;
    mask     = '0;

    w_ext    = MW'(rwc_nxt);
    o_ext    = MW'(roc_nxt);
    white_ok = (w_ext != '0) && (w_ext * MW'(20) > o_ext) &&
               (w_ext * MW'(100) < o_ext * MW'(99));

    if (is_green) begin
      if (in_field) begin
        if (!fr_v_nxt) begin
          fr_v_nxt = 1'b1;
          frs_nxt  = pos;
        end
        foc_nxt = '0;
        fgc_nxt = sat_inc(fgc_nxt);
        rgc_nxt = sat_inc(rgc_nxt);
        // Two greens in a row close the robot span.
        if (rgc_nxt > NB'(1)) begin
          if (roc_nxt != '0) begin
            if (rb_v_nxt && white_ok) begin
              mask[scrs_pkg::SLOT_ROBOT] = 1'b1;
            end
            roc_nxt = '0;
            rgc_nxt = '0;
            rwc_nxt = '0;
          end
          rb_v_nxt = 1'b0;
        end
      end
      mask[scrs_pkg::SLOT_OURS] = ou_v_nxt;
      mask[scrs_pkg::SLOT_OPPS] = op_v_nxt;
      ou_v_nxt = 1'b0;
      op_v_nxt = 1'b0;
    end else begin
      if (in_field) begin
        if (fr_v_nxt) begin
          foc_nxt = sat_inc(foc_nxt);
        end
        if (!rb_v_nxt) begin
          rb_v_nxt = 1'b1;
          rbs_nxt  = pos;
        end else begin
          roc_nxt = sat_inc(roc_nxt);
          if (is_white) begin
            rwc_nxt = sat_inc(rwc_nxt);
          end
        end
        rgc_nxt = '0;
      end
      mask[scrs_pkg::SLOT_OURS] = ou_v_nxt && !is_ours;
      if (!ou_v_nxt) begin
        ous_nxt = pos;
      end
      ou_v_nxt = is_ours;
      mask[scrs_pkg::SLOT_OPPS] = op_v_nxt && !is_opps;
      if (!op_v_nxt) begin
        ops_nxt = pos;
      end
      op_v_nxt = is_opps;
    end

    run_diff = $signed(CW'({1'b0, frs_nxt})) - CW'(fre_nxt);
    run_abs  = (run_diff < 0) ? -run_diff : run_diff;

    if (in_field && (foc_nxt > NB'(2) || at_limit)) begin
      if (fr_v_nxt && fgc_nxt > NB'(2)) begin
        // A run that starts farther from the last run's end than the last run was long replaces the span.
        if (run_abs > CW'(prl_base)) begin
          fmin_nxt = FMIN_W'(frs_nxt);
          fmax_nxt = pos;
        end else begin
          if (FMIN_W'(frs_nxt) < fmin_nxt) begin
            fmin_nxt = FMIN_W'(frs_nxt);
          end
          if (pos > fmax_nxt) begin
            fmax_nxt = pos;
          end
        end
        fre_nxt = $signed({1'b0, pos});
        ff_nxt  = 1'b1;
        prl_nxt = PRL_W'($signed({1'b0, pos}) - $signed({1'b0, frs_nxt}));
      end
      fr_v_nxt = 1'b0;
      fgc_nxt  = '0;
    end

    mask[scrs_pkg::SLOT_BORDER] = line_end && ff_nxt;
  end

  assign res_mask        = accept ? mask : '0;
  assign res_line        = line;
  assign res_end         = end_v;
  assign res_robot_start = rbs_nxt;
  assign res_ours_start  = ous_nxt;
  assign res_opps_start  = ops_nxt;
  assign res_field_min   = fmin_nxt[CB-1:0];
  assign res_field_max   = fmax_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
      frs_r  <= '0;
      fre_r  <= '1;
      fgc_r  <= '0;
      foc_r  <= '0;
      fmin_r <= FMIN_W'(scrs_pkg::LINE_LENGTH_RESET);
      fmax_r <= '0;
      ff_r   <= 1'b0;
      prl_r  <= PRL_W'(scrs_pkg::PREV_RESET);
      rb_v_r <= 1'b0;
      rbs_r  <= '0;
      rgc_r  <= '0;
      roc_r  <= '0;
      rwc_r  <= '0;
      ou_v_r <= 1'b0;
      ous_r  <= '0;
      op_v_r <= 1'b0;
      ops_r  <= '0;
    end else if (accept) begin
      fr_v_r <= fr_v_nxt;
      frs_r  <= frs_nxt;
      fre_r  <= fre_nxt;
      fgc_r  <= fgc_nxt;
      foc_r  <= foc_nxt;
      fmin_r <= fmin_nxt;
      fmax_r <= fmax_nxt;
      ff_r   <= ff_nxt;
      prl_r  <= prl_nxt;
      rb_v_r <= rb_v_nxt;
      rbs_r  <= rbs_nxt;
      rgc_r  <= rgc_nxt;
      roc_r  <= roc_nxt;
      rwc_r  <= rwc_nxt;
      ou_v_r <= ou_v_nxt;
      ous_r  <= ous_nxt;
      op_v_r <= op_v_nxt;
      ops_r  <= ops_nxt;
    end
  end

endmodule

### hdl/scrs_out_queue.sv
module scrs_out_queue #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [scrs_pkg::NUM_SLOTS-1:0] res_mask,
  input  logic [COORD_BITS-1:0] res_line,
  input  logic signed [COORD_BITS:0] res_end,
  input  logic [COORD_BITS-1:0] res_robot_start,
  input  logic [COORD_BITS-1:0] res_ours_start,
  input  logic [COORD_BITS-1:0] res_opps_start,
  input  logic [COORD_BITS-1:0] res_field_min,
  input  logic [COORD_BITS-1:0] res_field_max,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [COORD_BITS-1:0] out_line_coord,
  output logic [COORD_BITS-1:0] out_seg_start,
  output logic signed [COORD_BITS:0] out_seg_end,
  output logic                  out_last
);

  localparam int CB = COORD_BITS;

  // Bundle of results caused by one item, waiting for the output register.
  logic [scrs_pkg::NUM_SLOTS-1:0] mask_r, mask_nxt, pick, remain;
  logic [CB-1:0]      line_r, rbs_r, ous_r, ops_r, fmin_r, fmax_r;
  logic signed [CB:0] end_r;

  logic               out_valid_r, out_valid_nxt, out_last_r;
  logic [1:0]         out_kind_r, kind_sel;
  logic [CB-1:0]      out_line_r, out_start_r, start_sel;
  logic signed [CB:0] out_end_r, end_sel;
  logic               pop, accept;

  always_comb begin
    pick = '0;
    if (mask_r[scrs_pkg::SLOT_ROBOT]) begin
      pick[scrs_pkg::SLOT_ROBOT] = 1'b1;
    end else if (mask_r[scrs_pkg::SLOT_OURS]) begin
      pick[scrs_pkg::SLOT_OURS] = 1'b1;
    end else if (mask_r[scrs_pkg::SLOT_OPPS]) begin
      pick[scrs_pkg::SLOT_OPPS] = 1'b1;
    end else if (mask_r[scrs_pkg::SLOT_BORDER]) begin
      pick[scrs_pkg::SLOT_BORDER] = 1'b1;
    end
  end

  always_comb begin
    kind_sel  = scrs_pkg::KIND_BORDER;
    start_sel = fmin_r;
    end_sel   = $signed({1'b0, fmax_r});
    if (pick[scrs_pkg::SLOT_ROBOT]) begin
      kind_sel  = scrs_pkg::KIND_ROBOT;
      start_sel = rbs_r;
      end_sel   = end_r;
    end else if (pick[scrs_pkg::SLOT_OURS]) begin
      kind_sel  = scrs_pkg::KIND_OURS;
      start_sel = ous_r;
      end_sel   = end_r;
    end else if (pick[scrs_pkg::SLOT_OPPS]) begin
      kind_sel  = scrs_pkg::KIND_OPPS;
      start_sel = ops_r;
      end_sel   = end_r;
    end
  end

  assign remain   = mask_r & ~pick;
  assign pop      = (mask_r != '0) && (!out_valid_r || !out_stall);
  // The bundle takes a new item when empty or once its last result moves out this cycle.
  assign in_stall = (mask_r != '0) && !(pop && remain == '0);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      mask_nxt = res_mask;
    end else if (pop) begin
      mask_nxt = remain;
    end else begin
      mask_nxt = mask_r;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_line_coord = out_line_r;
  assign out_seg_start  = out_start_r;
  assign out_seg_end    = out_end_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r <= res_line;
      end_r  <= res_end;
      rbs_r  <= res_robot_start;
      ous_r  <= res_ours_start;
      ops_r  <= res_opps_start;
      fmin_r <= res_field_min;
      fmax_r <= res_field_max;
    end
    if (pop) begin
      out_kind_r  <= kind_sel;
      out_line_r  <= line_r;
      out_start_r <= start_sel;
      out_end_r   <= end_sel;
      out_last_r  <= (remain == '0);
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r != '0 && !pop) |-> in_stall)
    else $error("bundle overwritten while results are pending");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped result did not reach the output register");

  a_load_mask: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> mask_r == $past(res_mask))
    else $error("accepted item lost its results");

  a_not_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (mask_r != '0))
    else $error("result not marked last but no further result pending");
`endif

endmodule

### hdl/scanline_color_run_segmenter.sv
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall   | pos, line, class bits, line/frame marks
// out      | output    | out_valid / out_stall | kind, line_coord, seg_start, seg_end, last
// cfg      | input     | psel / penable        | 5 registers at byte addresses 0,4,..,16
//
// An item is taken every cycle while in_stall is low; run state updates on acceptance.
// Each item yields up to four results, sent one per cycle from a result bundle while
// out is not stalled; an item with more than one result stalls in until all are sent.
// Results pass through the result bundle and the output register before reaching out.
// Reset is synchronous and active low; it restores register defaults and run state.
// A stalled output holds its result while the bundle can still take one more item.
module scanline_color_run_segmenter #(
  parameter int COORD_BITS = 10,
  parameter int COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pos,
  input  logic [COORD_BITS-1:0] in_line,
  input  logic                  in_is_green,
  input  logic                  in_is_white,
  input  logic                  in_is_ours,
  input  logic                  in_is_opps,
  input  logic                  in_line_start,
  input  logic                  in_line_end,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [COORD_BITS-1:0] out_line_coord,
  output logic [COORD_BITS-1:0] out_seg_start,
  output logic signed [COORD_BITS:0] out_seg_end,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  scrs_pkg::cfg_t cfg;
  logic           accept;
  logic [scrs_pkg::NUM_SLOTS-1:0] res_mask;
  logic [COORD_BITS-1:0] res_line, res_robot_start, res_ours_start, res_opps_start;
  logic [COORD_BITS-1:0] res_field_min, res_field_max;
  logic signed [COORD_BITS:0] res_end;

  assign accept = in_valid && !in_stall;

  scrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scrs_run_core #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .accept          (accept),
    .pos             (in_pos),
    .line            (in_line),
    .is_green        (in_is_green),
    .is_white        (in_is_white),
    .is_ours         (in_is_ours),
    .is_opps         (in_is_opps),
    .line_start      (in_line_start),
    .line_end        (in_line_end),
    .frame_start     (in_frame_start),
    .res_mask        (res_mask),
    .res_line        (res_line),
    .res_end         (res_end),
    .res_robot_start (res_robot_start),
    .res_ours_start  (res_ours_start),
    .res_opps_start  (res_opps_start),
    .res_field_min   (res_field_min),
    .res_field_max   (res_field_max)
  );

  scrs_out_queue #(
    .COORD_BITS (COORD_BITS)
  ) u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_mask        (res_mask),
    .res_line        (res_line),
    .res_end         (res_end),
    .res_robot_start (res_robot_start),
    .res_ours_start  (res_ours_start),
    .res_opps_start  (res_opps_start),
    .res_field_min   (res_field_min),
    .res_field_max   (res_field_max),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_line_coord  (out_line_coord),
    .out_seg_start   (out_seg_start),
    .out_seg_end     (out_seg_end),
    .out_last        (out_last)
  );

endmodule

### sim/tb_scanline_color_run_segmenter.sv
module tb_scanline_color_run_segmenter;

  localparam int COORD_BITS = 10;
  localparam int COUNT_BITS = 10;
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

  // Flavors of the runs that the random scanlines are built from.
  localparam int RUN_GREEN = 0;
  localparam int RUN_BODY  = 1;
  localparam int RUN_OURS  = 2;
  localparam int RUN_OPPS  = 3;
  localparam int RUN_MIXED = 4;

  localparam int USE_PREDICTOR  = -1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [9:0] pos;
    logic [9:0] line;
    logic       green;
    logic       white;
    logic       ours;
    logic       opps;
    logic       line_start;
    logic       line_end;
    logic       frame_start;
  } sample_t;

  localparam int SAMPLE_BITS = $bits(sample_t);

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         line_coord;
    logic [9:0]         seg_start;
    logic signed [10:0] seg_end;
    logic               last;
  } seg_t;

  typedef struct {
    sample_t smp;
    int      typed_count;
    seg_t    typed;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [9:0]        in_pos = '0;
  logic [9:0]        in_line = '0;
  logic              in_is_green = 1'b0;
  logic              in_is_white = 1'b0;
  logic              in_is_ours = 1'b0;
  logic              in_is_opps = 1'b0;
  logic              in_line_start = 1'b0;
  logic              in_line_end = 1'b0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic [9:0]        out_line_coord;
  logic [9:0]        out_seg_start;
  logic signed [10:0] out_seg_end;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  always #10 clk = ~clk;

  scanline_color_run_segmenter #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pos(in_pos),
    .in_line(in_line),
    .in_is_green(in_is_green),
    .in_is_white(in_is_white),
    .in_is_ours(in_is_ours),
    .in_is_opps(in_is_opps),
    .in_line_start(in_line_start),
    .in_line_end(in_line_end),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_line_coord(out_line_coord),
    .out_seg_start(out_seg_start),
    .out_seg_end(out_seg_end),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Copy of the registers and of the run state, updated per accepted item.
  scrs_pkg::cfg_t cur_cfg;
  bit   fld_open;
  int   fld_start, fld_stop, fld_greens, fld_others, fld_min, fld_max;
  bit   fld_found;
  int   prev_len;
  bit   rob_open;
  int   rob_start, rob_greens, rob_others, rob_whites;
  bit   ours_open, opps_open;
  int   ours_from, opps_from;

  seg_t step_segments[$];
  seg_t expected_segments[$];
  probe_row_t probe_rows[$];

  int mismatches = 0;
  int tx_gap_pct = 35;
  int rx_stall_pct = 35;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic int sat_inc(int c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
  endfunction

  function automatic seg_t seg_of(logic [1:0] kind, int lc, int from, int upto, bit last);
    seg_t r;
    r.kind = kind;
    r.line_coord = 10'(lc);
    r.seg_start = 10'(from);
    r.seg_end = 11'(upto);
    r.last = last;
    return r;
  endfunction

  function automatic void post_segment(seg_t r);
    step_segments.insert(step_segments.size(), r);
  endfunction

  function automatic void expect_segment(seg_t r);
    expected_segments.insert(expected_segments.size(), r);
  endfunction

  function automatic sample_t mk_sample(int pos, int line, bit g, bit w, bit ou, bit op,
                                        bit ls, bit le, bit fs);
    sample_t s;
    s.pos = 10'(pos);
    s.line = 10'(line);
    s.green = g;
    s.white = w;
    s.ours = ou;
    s.opps = op;
    s.line_start = ls;
    s.line_end = le;
    s.frame_start = fs;
    return s;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void clear_line_state();
    fld_open = 1'b0;
    fld_start = 0;
    fld_stop = -1;
    fld_greens = 0;
    fld_others = 0;
    fld_min = int'(cur_cfg.line_length);
    fld_max = 0;
    fld_found = 1'b0;
    rob_open = 1'b0;
    rob_start = 0;
    rob_greens = 0;
    rob_others = 0;
    rob_whites = 0;
    ours_open = 1'b0;
    opps_open = 1'b0;
    ours_from = 0;
    opps_from = 0;
  endfunction

  // Advances the run state by one sample and leaves its results in step_segments.
  function automatic void advance_runs(sample_t s);
    int  p, stop, row, d;
    bit  in_fld;
    step_segments.delete();
    p = int'(s.pos);
    stop = p - int'(cur_cfg.scan_step);
    if (s.frame_start) prev_len = scrs_pkg::PREV_RESET;
    if (s.line_start) clear_line_state();
    row = cur_cfg.vertical_mode ? p : int'(s.line);
    in_fld = row > int'(cur_cfg.field_top);

    if (s.green) begin
      if (in_fld) begin
        if (!fld_open) begin
          fld_open = 1'b1;
          fld_start = p;
        end
        fld_others = 0;
        fld_greens = sat_inc(fld_greens);
        rob_greens = sat_inc(rob_greens);
        // Two greens in a row close a robot span.
        if (rob_greens > 1) begin
          if (rob_others != 0) begin
            if (rob_open && rob_whites > 0 && 20 * rob_whites > rob_others &&
                100 * rob_whites < 99 * rob_others) begin
              post_segment(seg_of(scrs_pkg::KIND_ROBOT, s.line, rob_start, stop, 1'b0));
            end
            rob_others = 0;
            rob_greens = 0;
            rob_whites = 0;
          end
          rob_open = 1'b0;
        end
      end
      if (ours_open) begin
        post_segment(seg_of(scrs_pkg::KIND_OURS, s.line, ours_from, stop, 1'b0));
        ours_open = 1'b0;
      end
      if (opps_open) begin
        post_segment(seg_of(scrs_pkg::KIND_OPPS, s.line, opps_from, stop, 1'b0));
        opps_open = 1'b0;
      end
    end else begin
      if (in_fld) begin
        if (fld_open) fld_others = sat_inc(fld_others);
        if (!rob_open) begin
          rob_open = 1'b1;
          rob_start = p;
        end else begin
          rob_others = sat_inc(rob_others);
          if (s.white) rob_whites = sat_inc(rob_whites);
        end
        rob_greens = 0;
      end
      if (!ours_open && s.ours) begin
        ours_open = 1'b1;
        ours_from = p;
      end
      if (!s.ours && ours_open) begin
        post_segment(seg_of(scrs_pkg::KIND_OURS, s.line, ours_from, stop, 1'b0));
        ours_open = 1'b0;
      end
      if (!opps_open && s.opps) begin
        opps_open = 1'b1;
        opps_from = p;
      end
      if (!s.opps && opps_open) begin
        post_segment(seg_of(scrs_pkg::KIND_OPPS, s.line, opps_from, stop, 1'b0));
        opps_open = 1'b0;
      end
    end

    if (in_fld && (fld_others > 2 || p >= int'(cur_cfg.scan_limit))) begin
      if (fld_open && fld_greens > 2) begin
        d = fld_start - fld_stop;
        if (d < 0) d = -d;
        // A run that starts farther from the previous run's end than the previous run was long replaces the span.
        if (d > prev_len) begin
          fld_min = fld_start;
          fld_max = p;
        end else begin
          if (fld_start < fld_min) fld_min = fld_start;
          if (p > fld_max) fld_max = p;
        end
        fld_stop = p;
        fld_found = 1'b1;
        prev_len = p - fld_start;
      end
      fld_open = 1'b0;
      fld_greens = 0;
    end

    if (s.line_end && fld_found) begin
      post_segment(seg_of(scrs_pkg::KIND_BORDER, s.line, fld_min, fld_max, 1'b0));
    end
    if (step_segments.size() > 0) step_segments[step_segments.size() - 1].last = 1'b1;
  endfunction

  task automatic present_sample(input sample_t s);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos <= s.pos;
    in_line <= s.line;
    in_is_green <= s.green;
    in_is_white <= s.white;
    in_is_ours <= s.ours;
    in_is_opps <= s.opps;
    in_line_start <= s.line_start;
    in_line_end <= s.line_end;
    in_frame_start <= s.frame_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed_sample(input sample_t s);
    present_sample(s);
    advance_runs(s);
    foreach (step_segments[k]) expect_segment(step_segments[k]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      scrs_pkg::REG_VERTICAL_MODE: cur_cfg.vertical_mode = value[0];
      scrs_pkg::REG_FIELD_TOP:     cur_cfg.field_top = value[10:0];
      scrs_pkg::REG_SCAN_STEP:     cur_cfg.scan_step = value[6:0];
      scrs_pkg::REG_SCAN_LIMIT:    cur_cfg.scan_limit = value[9:0];
      scrs_pkg::REG_LINE_LENGTH:   cur_cfg.line_length = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int vm, input int ft, input int step, input int lim,
                            input int ll);
    write_reg(scrs_pkg::REG_VERTICAL_MODE, 32'(vm));
    write_reg(scrs_pkg::REG_FIELD_TOP, 32'(ft) & 32'h7FF);
    write_reg(scrs_pkg::REG_SCAN_STEP, 32'(step));
    write_reg(scrs_pkg::REG_SCAN_LIMIT, 32'(lim));
    write_reg(scrs_pkg::REG_LINE_LENGTH, 32'(ll));
  endtask

  task automatic add_row(input sample_t s, input int n, input seg_t typed);
    probe_row_t r;
    r.smp = s;
    r.typed_count = n;
    r.typed = typed;
    probe_rows.insert(probe_rows.size(), r);
  endtask

  task automatic build_probe_table();
    seg_t none;
    none = '0;
    // Right after reset: row 0 is outside the field, so only jerseys count.
    add_row(mk_sample(0, 0, 0, 0, 1, 0, 1, 0, 1), 0, none);
    add_row(mk_sample(4, 0, 1, 0, 0, 0, 0, 0, 0), 1,
            seg_of(scrs_pkg::KIND_OURS, 0, 0, 0, 1'b1));
    add_row(mk_sample(1023, 1023, 0, 0, 0, 1, 1, 0, 0), 0, none);
    add_row(mk_sample(1023, 1023, 0, 1, 0, 0, 0, 0, 0), 1,
            seg_of(scrs_pkg::KIND_OPPS, 1023, 1023, 1019, 1'b1));
    // Green wins over every other class bit.
    add_row(mk_sample(1023, 1023, 1, 1, 1, 1, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(1023, 1023, 1, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    // A green run closed by three others, then a robot closed by two greens.
    add_row(mk_sample(0, 5, 1, 0, 0, 0, 1, 0, 1), USE_PREDICTOR, none);
    add_row(mk_sample(4, 5, 1, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(8, 5, 1, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(12, 5, 0, 1, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(16, 5, 0, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(20, 5, 0, 1, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(24, 5, 0, 1, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(28, 5, 1, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(32, 5, 1, 0, 0, 0, 0, 1, 0), USE_PREDICTOR, none);
    // A second line end without a line start reports the same span.
    add_row(mk_sample(36, 5, 0, 0, 0, 0, 0, 1, 0), 1,
            seg_of(scrs_pkg::KIND_BORDER, 5, 0, 20, 1'b1));
    // Segment end below zero.
    add_row(mk_sample(0, 1, 0, 0, 1, 0, 1, 0, 0), 0, none);
    add_row(mk_sample(0, 1, 0, 0, 0, 0, 0, 0, 0), 1,
            seg_of(scrs_pkg::KIND_OURS, 1, 0, -4, 1'b1));
    add_row(mk_sample(100, 1, 0, 0, 1, 1, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(104, 1, 1, 0, 0, 0, 0, 1, 0), USE_PREDICTOR, none);
    // A green run closed by reaching the scan limit, far enough from the last run's end to replace the span.
    add_row(mk_sample(630, 2, 1, 0, 0, 0, 1, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(634, 2, 1, 0, 0, 0, 0, 0, 0), USE_PREDICTOR, none);
    add_row(mk_sample(636, 2, 1, 0, 0, 0, 0, 1, 0), USE_PREDICTOR, none);
    add_row(mk_sample(700, 2, 0, 0, 0, 0, 0, 1, 1), USE_PREDICTOR, none);
  endtask

  // Scanlines of runs with random content; some lines are noise or lack a start or end.
  task automatic random_lines(input int n_items);
    int      made, len, base, lc, run_left, mode, pick;
    bit      noisy, keep_start, keep_end;
    sample_t s;
    made = 0;
    while (made < n_items) begin
      len = $urandom_range(3, 30);
      base = $urandom_range(0, 1023);
      lc = $urandom_range(0, 1023);
      noisy = $urandom_range(0, 9) == 0;
      keep_start = $urandom_range(0, 9) != 0;
      keep_end = $urandom_range(0, 9) != 0;
      run_left = 0;
      mode = RUN_GREEN;
      for (int i = 0; i < len; i++) begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 9);
          mode = pick < 4 ? RUN_GREEN : pick < 7 ? RUN_BODY : pick == 7 ? RUN_OURS :
                 pick == 8 ? RUN_OPPS : RUN_MIXED;
          run_left = $urandom_range(1, 6);
        end
        run_left--;
        s = '0;
        s.pos = 10'(base + i * int'(cur_cfg.scan_step));
        s.line = 10'(lc);
        case (mode)
          RUN_GREEN: begin
            s.green = 1'b1;
            s.white = $urandom_range(0, 7) == 0;
          end
          RUN_BODY: begin
            s.white = 1'($urandom_range(0, 1));
            s.ours = $urandom_range(0, 7) == 0;
            s.opps = $urandom_range(0, 7) == 0;
          end
          RUN_OURS: begin
            s.ours = 1'b1;
            s.opps = $urandom_range(0, 3) == 0;
            s.white = $urandom_range(0, 3) == 0;
          end
          RUN_OPPS: begin
            s.opps = 1'b1;
            s.ours = $urandom_range(0, 3) == 0;
            s.white = $urandom_range(0, 3) == 0;
          end
          default: begin
            s.green = 1'($urandom_range(0, 1));
            s.white = 1'($urandom_range(0, 1));
            s.ours = 1'($urandom_range(0, 1));
            s.opps = 1'($urandom_range(0, 1));
          end
        endcase
        s.line_start = keep_start && i == 0;
        s.line_end = keep_end && i == len - 1;
        s.frame_start = i == 0 && $urandom_range(0, 7) == 0;
        if (noisy) s = SAMPLE_BITS'($urandom);
        feed_sample(s);
        made++;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < rx_stall_pct;
    end
  end

  always @(posedge clk) begin : check_results
    seg_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind;
      got.line_coord = out_line_coord;
      got.seg_start = out_seg_start;
      got.seg_end = out_seg_end;
      got.last = out_last;
      if (expected_segments.size() == 0) begin
        note_mismatch($sformatf("unexpected segment: kind %0d line %0d start %0d end %0d last %0b",
                                got.kind, got.line_coord, got.seg_start, got.seg_end, got.last));
      end else begin
        want = expected_segments.pop_front();
        if (got.kind !== want.kind || got.line_coord !== want.line_coord ||
            got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
            got.last !== want.last) begin
          note_mismatch($sformatf({"segment differs: expected kind %0d line %0d start %0d ",
                                   "end %0d last %0b, got kind %0d line %0d start %0d ",
                                   "end %0d last %0b"},
                                  want.kind, want.line_coord, want.seg_start, want.seg_end,
                                  want.last, got.kind, got.line_coord, got.seg_start,
                                  got.seg_end, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cur_cfg.vertical_mode = 1'b0;
    cur_cfg.field_top = '0;
    cur_cfg.scan_step = scrs_pkg::SCAN_STEP_RESET;
    cur_cfg.scan_limit = scrs_pkg::SCAN_LIMIT_RESET;
    cur_cfg.line_length = scrs_pkg::LINE_LENGTH_RESET;
    prev_len = scrs_pkg::PREV_RESET;
    clear_line_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_probe_table();
    foreach (probe_rows[i]) begin
      present_sample(probe_rows[i].smp);
      advance_runs(probe_rows[i].smp);
      if (probe_rows[i].typed_count == USE_PREDICTOR) begin
        foreach (step_segments[k]) expect_segment(step_segments[k]);
      end else if (probe_rows[i].typed_count == 1) begin
        expect_segment(probe_rows[i].typed);
      end
    end
    settle();

    tx_gap_pct = 0;
    rx_stall_pct = 0;
    random_lines(50);
    tx_gap_pct = 35;
    rx_stall_pct = 35;
    random_lines(90);
    // The receiver holds off while the sender keeps offering items.
    hold_requests++;
    random_lines(50);
    settle();

    set_config(1, -64, 1, 0, 1024);
    random_lines(40);
    settle();
    set_config(0, 1023, 64, 1023, 1);
    random_lines(30);
    settle();

    repeat (3) begin
      set_config($urandom_range(0, 1),
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1087)) - 64 :
                                               int'($urandom_range(0, 128)) - 64,
                 $urandom_range(1, 64), $urandom_range(0, 1023), $urandom_range(1, 1024));
      random_lines(35);
      settle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### scanline_color_run_segmenter.f
hdl/scrs_pkg.sv
hdl/scrs_cfg.sv
hdl/scrs_run_core.sv
hdl/scrs_out_queue.sv
hdl/scanline_color_run_segmenter.sv
sim/tb_scanline_color_run_segmenter.sv
